// ----- hdl/pms_pkg.sv -----
// Shared types, codes and constants of the plunger motor sequencer.
package pms_pkg;

    localparam int PROFILE_COUNT_DEF = 5;
    localparam int DURATION_BITS_DEF = 8;
    localparam int PROFILE_SLOTS     = 5;
    localparam int REG_BITS          = 40;
    localparam int DATA_BITS         = 64;
    localparam int ADDR_BITS         = 5;

    localparam logic [1:0] REG_PUSH = 2'd0;
    localparam logic [1:0] REG_HOLD = 2'd1;
    localparam logic [1:0] REG_PULL = 2'd2;

    localparam logic [1:0] STEP_LEFT  = 2'd1;
    localparam logic [1:0] STEP_RIGHT = 2'd2;

    localparam logic [2:0] MENU_FIRST   = 3'd0;
    localparam logic [2:0] MENU_JOG_FWD = 3'd5;
    localparam logic [2:0] MENU_JOG_REV = 3'd6;
    localparam logic [2:0] MENU_SETUP   = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PUSH    = 3'd1,
        PH_HOLD    = 3'd2,
        PH_PULL    = 3'd3,
        PH_RELEASE = 3'd4,
        PH_JOG     = 3'd5,
        PH_KNOB    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        DRV_SLEEP   = 2'd0,
        DRV_FORWARD = 2'd1,
        DRV_BRAKE   = 2'd2,
        DRV_REVERSE = 2'd3
    } t_drive;

    typedef struct packed {
        logic [REG_BITS-1:0] push_times;
        logic [REG_BITS-1:0] hold_times;
        logic [REG_BITS-1:0] pull_times;
    } t_timing;

endpackage

// ----- hdl/pms_regs.sv -----
// APB register file holding the push, hold and pull duration tables.
module pms_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pms_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [pms_pkg::DATA_BITS-1:0]  pwdata,
    output logic [pms_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output pms_pkg::t_timing               o_timing
);

    logic [pms_pkg::REG_BITS-1:0] r_push;
    logic [pms_pkg::REG_BITS-1:0] r_hold;
    logic [pms_pkg::REG_BITS-1:0] r_pull;
    logic [1:0]                   reg_sel;
    logic                         wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= '0;
            r_hold <= '0;
            r_pull <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                pms_pkg::REG_PUSH: r_push <= pwdata[pms_pkg::REG_BITS-1:0];
                pms_pkg::REG_HOLD: r_hold <= pwdata[pms_pkg::REG_BITS-1:0];
                pms_pkg::REG_PULL: r_pull <= pwdata[pms_pkg::REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            pms_pkg::REG_PUSH: prdata = {{(pms_pkg::DATA_BITS-pms_pkg::REG_BITS){1'b0}}, r_push};
            pms_pkg::REG_HOLD: prdata = {{(pms_pkg::DATA_BITS-pms_pkg::REG_BITS){1'b0}}, r_hold};
            pms_pkg::REG_PULL: prdata = {{(pms_pkg::DATA_BITS-pms_pkg::REG_BITS){1'b0}}, r_pull};
            default:           prdata = '0;
        endcase
    end

    assign o_timing.push_times = r_push;
    assign o_timing.hold_times = r_hold;
    assign o_timing.pull_times = r_pull;

endmodule

// ----- hdl/pms_core.sv -----
// Sequencer core: input register, phase state machine and result register.
module pms_core #(
    parameter int PROFILE_COUNT = pms_pkg::PROFILE_COUNT_DEF,
    parameter int DURATION_BITS = pms_pkg::DURATION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pms_pkg::t_timing i_timing,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_rotary_step,
    input  logic             i_main_button,
    input  logic             i_external_button,
    input  logic             i_knob_button,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_motor_drive,
    output logic             o_display_inverted,
    output logic [2:0]       o_menu_position,
    output logic             o_settings_request
);

    localparam int LIVE_PROFILES = (PROFILE_COUNT < pms_pkg::PROFILE_SLOTS) ?
                                   PROFILE_COUNT : pms_pkg::PROFILE_SLOTS;

    function automatic logic [DURATION_BITS-1:0] f_field(
        input logic [pms_pkg::REG_BITS-1:0] reg_val,
        input logic [2:0]                   prof
    );
        logic [pms_pkg::REG_BITS-1:0] shifted;
        shifted = reg_val >> (int'(prof) * DURATION_BITS);
        return shifted[DURATION_BITS-1:0];
    endfunction

    logic                     r_in_valid;
    logic [1:0]               r_in_step;
    logic                     r_in_trig;
    logic                     r_in_knob;

    pms_pkg::t_phase          r_phase;
    pms_pkg::t_phase          n_phase;
    logic [2:0]               r_menu;
    logic [2:0]               n_menu;
    logic [DURATION_BITS-1:0] r_count;
    logic [DURATION_BITS-1:0] n_count;
    logic [2:0]               r_profile;
    logic [2:0]               n_profile;

    logic                     r_out_valid;
    pms_pkg::t_drive          r_out_drive;
    logic [2:0]               r_out_menu;
    logic                     r_out_req;

    pms_pkg::t_drive          drive;
    logic                     req;
    logic                     advance;
    logic [2:0]               sel_prof;
    logic [DURATION_BITS-1:0] d_push;
    logic [DURATION_BITS-1:0] d_hold;
    logic [DURATION_BITS-1:0] d_pull;
    logic                     enter_req;
    pms_pkg::t_phase          enter_from;
    logic                     enter_held;
    pms_pkg::t_drive          jog_drive;

    assign advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_step <= i_rotary_step;
            r_in_trig <= i_main_button | i_external_button;
            r_in_knob <= i_knob_button;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pms_pkg::PH_IDLE;
            r_menu    <= pms_pkg::MENU_FIRST;
            r_count   <= '0;
            r_profile <= '0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_menu    <= n_menu;
            r_count   <= n_count;
            r_profile <= n_profile;
        end
    end

    always_comb begin
        n_menu = r_menu;
        if (r_phase == pms_pkg::PH_IDLE) begin
            if (r_in_step == pms_pkg::STEP_LEFT && r_menu != pms_pkg::MENU_FIRST) begin
                n_menu = r_menu - 3'd1;
            end else if (r_in_step == pms_pkg::STEP_RIGHT &&
                         r_menu != pms_pkg::MENU_SETUP) begin
                n_menu = r_menu + 3'd1;
            end
        end
    end

    assign sel_prof  = (r_phase == pms_pkg::PH_IDLE) ? n_menu : r_profile;
    assign d_push    = f_field(i_timing.push_times, sel_prof);
    assign d_hold    = f_field(i_timing.hold_times, sel_prof);
    assign d_pull    = f_field(i_timing.pull_times, sel_prof);
    assign jog_drive = (n_menu == pms_pkg::MENU_JOG_FWD) ?
                       pms_pkg::DRV_FORWARD : pms_pkg::DRV_REVERSE;

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_profile  = r_profile;
        drive      = pms_pkg::DRV_SLEEP;
        req        = 1'b0;
        enter_req  = 1'b0;
        enter_from = pms_pkg::PH_PUSH;
        enter_held = 1'b1;
        case (r_phase)
            pms_pkg::PH_IDLE: begin
                if (int'(n_menu) < LIVE_PROFILES) begin
                    if (r_in_trig) begin
                        n_profile  = n_menu;
                        enter_req  = 1'b1;
                        enter_from = pms_pkg::PH_PUSH;
                        enter_held = 1'b1;
                    end
                end else if (n_menu == pms_pkg::MENU_JOG_FWD ||
                             n_menu == pms_pkg::MENU_JOG_REV) begin
                    if (r_in_trig || r_in_knob) begin
                        n_phase = pms_pkg::PH_JOG;
                        drive   = jog_drive;
                    end
                end else if (n_menu == pms_pkg::MENU_SETUP) begin
                    if (r_in_knob) begin
                        n_phase = pms_pkg::PH_KNOB;
                    end
                end
            end
            pms_pkg::PH_PUSH, pms_pkg::PH_HOLD, pms_pkg::PH_PULL: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                    case (r_phase)
                        pms_pkg::PH_PUSH: drive = pms_pkg::DRV_FORWARD;
                        pms_pkg::PH_HOLD: drive = pms_pkg::DRV_BRAKE;
                        default:          drive = pms_pkg::DRV_REVERSE;
                    endcase
                end else begin
                    enter_req  = 1'b1;
                    enter_held = r_in_trig;
                    case (r_phase)
                        pms_pkg::PH_PUSH: enter_from = pms_pkg::PH_HOLD;
                        pms_pkg::PH_HOLD: enter_from = pms_pkg::PH_PULL;
                        default:          enter_from = pms_pkg::PH_RELEASE;
                    endcase
                end
            end
            pms_pkg::PH_RELEASE: begin
                if (!r_in_trig) begin
                    n_phase = pms_pkg::PH_IDLE;
                end
            end
            pms_pkg::PH_JOG: begin
                if (r_in_trig || r_in_knob) begin
                    drive = jog_drive;
                end else begin
                    n_phase = pms_pkg::PH_IDLE;
                end
            end
            pms_pkg::PH_KNOB: begin
                if (!r_in_knob) begin
                    req     = 1'b1;
                    n_phase = pms_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = pms_pkg::PH_IDLE;
            end
        endcase

        if (enter_req) begin
            if (enter_from == pms_pkg::PH_PUSH && d_push != '0) begin
                n_phase = pms_pkg::PH_PUSH;
                n_count = d_push - 1'b1;
                drive   = pms_pkg::DRV_FORWARD;
            end else if ((enter_from == pms_pkg::PH_PUSH || enter_from == pms_pkg::PH_HOLD)
                         && d_hold != '0) begin
                n_phase = pms_pkg::PH_HOLD;
                n_count = d_hold - 1'b1;
                drive   = pms_pkg::DRV_BRAKE;
            end else if (enter_from != pms_pkg::PH_RELEASE && d_pull != '0) begin
                n_phase = pms_pkg::PH_PULL;
                n_count = d_pull - 1'b1;
                drive   = pms_pkg::DRV_REVERSE;
            end else begin
                n_phase = enter_held ? pms_pkg::PH_RELEASE : pms_pkg::PH_IDLE;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_drive <= drive;
            r_out_menu  <= n_menu;
            r_out_req   <= req;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_motor_drive      = r_out_drive;
    assign o_display_inverted = (r_out_drive != pms_pkg::DRV_SLEEP);
    assign o_menu_position    = r_out_menu;
    assign o_settings_request = r_out_req;

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pms_pkg::PH_IDLE || r_phase == pms_pkg::PH_RELEASE ||
         r_phase == pms_pkg::PH_JOG || r_phase == pms_pkg::PH_KNOB) |-> r_count == '0)
        else $error("countdown not cleared outside a timed phase");

    a_menu_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_phase != pms_pkg::PH_IDLE) |=> r_menu == $past(r_menu))
        else $error("menu moved while a motor action was running");

    a_req_menu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_req) |-> r_out_menu == pms_pkg::MENU_SETUP)
        else $error("settings request away from the settings position");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_ready)
        else $error("input stalled with an empty result register");

endmodule

// ----- hdl/plunger_motor_sequencer.sv -----
// Top level of the plunger motor sequencer: register file and sequencer core.
// The block takes one tick word per clock cycle while the output is not
// stalled and returns one result word per tick, held in the input register
// and then carried through the phase state machine into the result register.
// The phase, countdown and menu state update once per word, so a new word can
// follow in every cycle while the output is not stalled. Duration tables are
// written through the APB port at byte addresses 0, 8 and 16; the user must
// do so only while no word is in flight, as the block does not enforce this.
module plunger_motor_sequencer #(
    parameter int PROFILE_COUNT = pms_pkg::PROFILE_COUNT_DEF,
    parameter int DURATION_BITS = pms_pkg::DURATION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pms_pkg::ADDR_BITS-1:0] paddr,
    input  logic [pms_pkg::DATA_BITS-1:0] pwdata,
    output logic [pms_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_rotary_step,
    input  logic                          i_main_button,
    input  logic                          i_external_button,
    input  logic                          i_knob_button,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_motor_drive,
    output logic                          o_display_inverted,
    output logic [2:0]                    o_menu_position,
    output logic                          o_settings_request
);

    pms_pkg::t_timing timing;

    pms_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_timing (timing)
    );

    pms_core #(
        .PROFILE_COUNT (PROFILE_COUNT),
        .DURATION_BITS (DURATION_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_timing           (timing),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_rotary_step      (i_rotary_step),
        .i_main_button      (i_main_button),
        .i_external_button  (i_external_button),
        .i_knob_button      (i_knob_button),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_motor_drive      (o_motor_drive),
        .o_display_inverted (o_display_inverted),
        .o_menu_position    (o_menu_position),
        .o_settings_request (o_settings_request)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the plunger motor sequencer: tick words in, drive words out.
module testbench;

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_ODD  = 2'd3;
    localparam int DUR_BITS    = pms_pkg::DURATION_BITS_DEF;
    localparam int REG_W       = pms_pkg::REG_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF    = 300;

    typedef struct packed {
        pms_pkg::t_drive drive;
        logic            inverted;
        logic [2:0]      position;
        logic            request;
    } t_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pms_pkg::ADDR_BITS-1:0] paddr;
    logic [pms_pkg::DATA_BITS-1:0] pwdata;
    logic [pms_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;
    logic                          i_valid;
    logic                          o_ready;
    logic [1:0]                    i_rotary_step;
    logic                          i_main_button;
    logic                          i_external_button;
    logic                          i_knob_button;
    logic                          o_valid;
    logic                          i_ready;
    logic [1:0]                    o_motor_drive;
    logic                          o_display_inverted;
    logic [2:0]                    o_menu_position;
    logic                          o_settings_request;

    plunger_motor_sequencer dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_rotary_step(i_rotary_step),
        .i_main_button(i_main_button),
        .i_external_button(i_external_button),
        .i_knob_button(i_knob_button),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_motor_drive(o_motor_drive),
        .o_display_inverted(o_display_inverted),
        .o_menu_position(o_menu_position),
        .o_settings_request(o_settings_request)
    );

    logic [REG_W-1:0]    push_tbl = '0;
    logic [REG_W-1:0]    hold_tbl = '0;
    logic [REG_W-1:0]    pull_tbl = '0;
    logic [2:0]          seq_menu = pms_pkg::MENU_FIRST;
    pms_pkg::t_phase     seq_phase = pms_pkg::PH_IDLE;
    logic [DUR_BITS-1:0] seq_count = '0;
    logic [2:0]          seq_profile = '0;

    t_result pending_results[$];
    t_result want;
    int      errors = 0;
    int      words_sent = 0;
    int      words_checked = 0;
    int      reg_writes = 0;
    int      runs_started = 0;
    int      jog_actions = 0;
    int      settings_pulses = 0;
    int      stall_cycles = 0;
    int      hold_order = 0;
    int      hold_left = 0;
    bit      gaps_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DUR_BITS-1:0] phase_length(input int p);
        logic [REG_W-1:0] tbl;
        tbl = (p == int'(pms_pkg::PH_PUSH)) ? push_tbl :
              (p == int'(pms_pkg::PH_HOLD)) ? hold_tbl : pull_tbl;
        return DUR_BITS'(tbl >> (int'(seq_profile) * DUR_BITS));
    endfunction

    function automatic pms_pkg::t_drive start_from(input int first, input logic held);
        logic [DUR_BITS-1:0] d;
        for (int p = first; p <= int'(pms_pkg::PH_PULL); p++) begin
            d = phase_length(p);
            if (d != 0) begin
                seq_phase = pms_pkg::t_phase'(p);
                seq_count = d - 1'b1;
                return pms_pkg::t_drive'(p);
            end
        end
        seq_phase = held ? pms_pkg::PH_RELEASE : pms_pkg::PH_IDLE;
        seq_count = '0;
        return pms_pkg::DRV_SLEEP;
    endfunction

    function automatic pms_pkg::t_drive jog_drive();
        return (seq_menu == pms_pkg::MENU_JOG_FWD) ? pms_pkg::DRV_FORWARD : pms_pkg::DRV_REVERSE;
    endfunction

    function automatic t_result advance_sequencer(input logic [1:0] step, input logic trig,
                                                  input logic knob);
        t_result         r;
        pms_pkg::t_drive drv;
        logic            req;
        drv = pms_pkg::DRV_SLEEP;
        req = 1'b0;
        case (seq_phase)
            pms_pkg::PH_IDLE: begin
                if (step == pms_pkg::STEP_LEFT && seq_menu > pms_pkg::MENU_FIRST) begin
                    seq_menu = seq_menu - 1'b1;
                end else if (step == pms_pkg::STEP_RIGHT && seq_menu < pms_pkg::MENU_SETUP) begin
                    seq_menu = seq_menu + 1'b1;
                end
                if (seq_menu < pms_pkg::PROFILE_COUNT_DEF && seq_menu < pms_pkg::MENU_JOG_FWD) begin
                    if (trig) begin
                        seq_profile = seq_menu;
                        runs_started++;
                        drv = start_from(int'(pms_pkg::PH_PUSH), 1'b1);
                    end
                end else if (seq_menu == pms_pkg::MENU_JOG_FWD ||
                             seq_menu == pms_pkg::MENU_JOG_REV) begin
                    if (trig || knob) begin
                        seq_phase = pms_pkg::PH_JOG;
                        jog_actions++;
                        drv = jog_drive();
                    end
                end else if (seq_menu == pms_pkg::MENU_SETUP) begin
                    if (knob) seq_phase = pms_pkg::PH_KNOB;
                end
            end
            pms_pkg::PH_PUSH, pms_pkg::PH_HOLD, pms_pkg::PH_PULL: begin
                if (seq_count != 0) begin
                    seq_count = seq_count - 1'b1;
                    drv = pms_pkg::t_drive'(seq_phase[1:0]);
                end else begin
                    drv = start_from(int'(seq_phase) + 1, trig);
                end
            end
            pms_pkg::PH_RELEASE: begin
                if (!trig) seq_phase = pms_pkg::PH_IDLE;
            end
            pms_pkg::PH_JOG: begin
                if (trig || knob) drv = jog_drive();
                else seq_phase = pms_pkg::PH_IDLE;
            end
            pms_pkg::PH_KNOB: begin
                if (!knob) begin
                    req = 1'b1;
                    settings_pulses++;
                    seq_phase = pms_pkg::PH_IDLE;
                end
            end
            default: seq_phase = pms_pkg::PH_IDLE;
        endcase
        r.drive = drv;
        r.inverted = (drv != pms_pkg::DRV_SLEEP);
        r.position = seq_menu;
        r.request = req;
        return r;
    endfunction

    function automatic logic [1:0] rand_step();
        return ($urandom_range(99) < 75) ? STEP_NONE : 2'($urandom_range(3, 1));
    endfunction

    function automatic logic [REG_W-1:0] short_durations();
        logic [REG_W-1:0] v;
        for (int i = 0; i < pms_pkg::PROFILE_SLOTS; i++) begin
            v[i*DUR_BITS +: DUR_BITS] = ($urandom_range(3) == 0) ? '0 :
                                        DUR_BITS'($urandom_range(6, 1));
        end
        return v;
    endfunction

    task automatic send_tick(input logic [1:0] step, input logic main_b, input logic ext_b,
                             input logic knob_b);
        while (gaps_on && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rotary_step <= step;
        i_main_button <= main_b;
        i_external_button <= ext_b;
        i_knob_button <= knob_b;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        pending_results.push_back(advance_sequencer(step, main_b | ext_b, knob_b));
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [REG_W-1:0] value);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pms_pkg::ADDR_BITS'(idx) << 3;
        pwdata <= {junk[pms_pkg::DATA_BITS-1:REG_W], value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
        case (idx)
            pms_pkg::REG_PUSH: push_tbl = value;
            pms_pkg::REG_HOLD: hold_tbl = value;
            pms_pkg::REG_PULL: pull_tbl = value;
            default: ;
        endcase
    endtask

    task automatic write_durations(input logic [REG_W-1:0] push_v,
                                   input logic [REG_W-1:0] hold_v,
                                   input logic [REG_W-1:0] pull_v);
        wait_for_results();
        write_register(pms_pkg::REG_PUSH, push_v);
        write_register(pms_pkg::REG_HOLD, hold_v);
        write_register(pms_pkg::REG_PULL, pull_v);
    endtask

    task automatic go_to_position(input logic [2:0] target);
        while (seq_menu != target || seq_phase != pms_pkg::PH_IDLE) begin
            send_tick((seq_phase != pms_pkg::PH_IDLE) ? STEP_NONE :
                      (seq_menu < target) ? pms_pkg::STEP_RIGHT : pms_pkg::STEP_LEFT,
                      1'b0, 1'b0, 1'b0);
        end
    endtask

    task automatic test_directed();
        send_tick(pms_pkg::STEP_LEFT, 1'b0, 1'b0, 1'b0);
        send_tick(STEP_ODD, 1'b0, 1'b0, 1'b0);
        send_tick(STEP_NONE, 1'b1, 1'b0, 1'b0);
        send_tick(STEP_NONE, 1'b1, 1'b0, 1'b0);
        send_tick(pms_pkg::STEP_RIGHT, 1'b0, 1'b0, 1'b0);
        write_durations(40'h00_00_00_00_02, 40'h00_00_00_01_00, 40'h00_00_00_00_01);
        send_tick(STEP_NONE, 1'b0, 1'b1, 1'b0);
        send_tick(pms_pkg::STEP_RIGHT, 1'b0, 1'b1, 1'b0);
        send_tick(STEP_NONE, 1'b0, 1'b0, 1'b0);
        send_tick(STEP_NONE, 1'b0, 1'b0, 1'b0);
        send_tick(pms_pkg::STEP_RIGHT, 1'b1, 1'b1, 1'b0);
        send_tick(STEP_NONE, 1'b1, 1'b0, 1'b0);
        send_tick(STEP_NONE, 1'b0, 1'b0, 1'b1);
        repeat (7) send_tick(pms_pkg::STEP_RIGHT, 1'b0, 1'b0, 1'b0);
        send_tick(STEP_NONE, 1'b1, 1'b1, 1'b0);
        send_tick(STEP_NONE, 1'b0, 1'b0, 1'b1);
        send_tick(pms_pkg::STEP_LEFT, 1'b0, 1'b0, 1'b1);
        send_tick(pms_pkg::STEP_LEFT, 1'b0, 1'b0, 1'b0);
        send_tick(STEP_NONE, 1'b0, 1'b0, 1'b1);
        send_tick(STEP_NONE, 1'b0, 1'b0, 1'b0);
        send_tick(pms_pkg::STEP_LEFT, 1'b1, 1'b0, 1'b0);
        send_tick(STEP_NONE, 1'b0, 1'b0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_long_phases();
        write_durations(40'hFF_FF_FF_FF_01, {REG_W{1'b1}}, 40'h00_00_00_00_01);
        go_to_position(pms_pkg::MENU_FIRST);
        send_tick(STEP_NONE, 1'b1, 1'b1, 1'b0);
        repeat (262) send_tick(rand_step(), 1'b0, 1'b0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        wait_for_results();
        hold_order = HOLD_OFF;
        repeat (40) begin
            send_tick(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic(input logic [REG_W-1:0] push_v,
                                       input logic [REG_W-1:0] hold_v,
                                       input logic [REG_W-1:0] pull_v,
                                       input bit idle_on, input int count);
        int   stop_at;
        int   which;
        logic knob_noise;
        write_durations(push_v, hold_v, pull_v);
        gaps_on = idle_on;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    repeat ($urandom_range(3, 1)) send_tick(2'($urandom_range(3)), 1'b0, 1'b0, 1'b0);
                end
                3, 4, 5, 6: begin
                    which = $urandom_range(3, 1);
                    repeat ($urandom_range(12, 1)) begin
                        knob_noise = ($urandom_range(9) == 0);
                        send_tick(rand_step(), which[0], which[1], knob_noise);
                    end
                    repeat ($urandom_range(12)) send_tick(rand_step(), 1'b0, 1'b0, 1'b0);
                end
                7: begin
                    repeat ($urandom_range(4, 1)) send_tick(rand_step(), 1'b0, 1'b0, 1'b1);
                    repeat ($urandom_range(3, 1)) send_tick(rand_step(), 1'b0, 1'b0, 1'b0);
                end
                default: begin
                    send_tick(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end
            endcase
        end
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_order != 0) begin
                hold_left = hold_order;
                hold_order = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(gaps_on && $urandom_range(99) < 15);
            end
        end
    end

    task automatic check_field(input string what, input int expected, input int actual);
        if (expected != actual) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            words_checked++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual drive %0d menu %0d",
                         $time, o_motor_drive, o_menu_position);
            end else begin
                want = pending_results.pop_front();
                check_field("motor_drive", want.drive, o_motor_drive);
                check_field("display_inverted", want.inverted, o_display_inverted);
                check_field("menu_position", want.position, o_menu_position);
                check_field("settings_request", want.request, o_settings_request);
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || psel || (i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, pending_results.size());
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_rotary_step <= STEP_NONE;
        i_main_button <= 1'b0;
        i_external_button <= 1'b0;
        i_knob_button <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_phases();
        test_backpressure();
        test_random_traffic(short_durations(), '0, short_durations(), 1'b1, 175);
        test_random_traffic(short_durations(), short_durations(), short_durations(), 1'b0, 175);
        test_random_traffic('0, short_durations(), short_durations(), 1'b1, 175);
        test_random_traffic(short_durations(), short_durations(), '0, 1'b1, 175);
        wait_for_results();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d tick words and checked %0d result words over %0d register writes.",
                 words_sent, words_checked, reg_writes);
        $display("Covered %0d profile runs, %0d jog actions and %0d settings requests.",
                 runs_started, jog_actions, settings_pulses);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pms_pkg.sv
hdl/pms_regs.sv
hdl/pms_core.sv
hdl/plunger_motor_sequencer.sv
test/testbench.sv
